@@ hw/rtl/ftrb_pkg.sv @@
// Shared constants, types and wave tables of the tape tone ring buffer.
// Used by every file of the block; depends on nothing else.

package ftrb_pkg;

	localparam int RING_DEPTH = 16384;
	localparam int FAST_LEN   = 36;
	localparam int SLOW_LEN   = FAST_LEN + 1;

	localparam int ADDR_W     = $clog2(RING_DEPTH);
	localparam int CNT_W      = ADDR_W + 1;
	localparam int K_W        = $clog2(SLOW_LEN);
	localparam int SAMPLE_W   = 16;
	localparam int FILL_W     = 14;
	localparam int STATUS_W   = 3;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 1;

	localparam logic [CNT_W-1:0]  DEPTH_C     = CNT_W'(RING_DEPTH);
	localparam logic [CNT_W-1:0]  LEN_FAST    = CNT_W'(FAST_LEN);
	localparam logic [CNT_W-1:0]  LEN_SLOW    = CNT_W'(SLOW_LEN);
	localparam logic [ADDR_W-1:0] FILL_HALF   = ADDR_W'(RING_DEPTH / 2);
	localparam logic [ADDR_W-1:0] FILL_3Q     = ADDR_W'((3 * RING_DEPTH) / 4);
	localparam logic [ADDR_W-1:0] FILL_1Q     = ADDR_W'(RING_DEPTH / 4);
	localparam logic [ADDR_W-1:0] PTR_LAST    = ADDR_W'(RING_DEPTH - 1);
	localparam logic [ADDR_W-1:0] CLEAR_LAST  = ADDR_W'(RING_DEPTH / 2 - 1);
	localparam logic [K_W-1:0]    K_LAST_FAST = K_W'(FAST_LEN - 1);
	localparam logic [K_W-1:0]    K_LAST_SLOW = K_W'(SLOW_LEN - 1);

	localparam logic [CFG_IDX_W-1:0] CFG_SOUND_ENABLE = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_HYSTERESIS   = CFG_IDX_W'(1);

	typedef enum logic [1:0] {
		ACT_TONE,
		ACT_READ,
		ACT_FLUSH,
		ACT_ACTIVATE
	} action_t;

	typedef enum logic [1:0] {
		TONE_SPACE,
		TONE_MARK,
		TONE_LEADER,
		TONE_SILENCE
	} tone_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_WRITTEN,
		STAT_SKIPPED,
		STAT_FULL,
		STAT_SOUND_OFF,
		STAT_NOT_TONE
	} status_t;

	// One access to the sample ring: a write when we is set, otherwise a read.
	typedef struct packed {
		logic                we;
		logic [ADDR_W-1:0]   addr;
		logic [SAMPLE_W-1:0] wdata;
	} ring_req_t;

	// Selection of one wave table entry.
	typedef struct packed {
		logic           fast;
		logic           two;
		logic           silent;
		logic [K_W-1:0] k;
	} wave_sel_t;

	typedef logic [SLOW_LEN-1:0][SAMPLE_W-1:0] wave_tab_t;

	// Q30 fixed-point angles, with pi taken as the true value.
	localparam logic [63:0] Q30_ONE     = 64'd1073741824;
	localparam logic [63:0] Q30_PI      = 64'd3373259426;
	localparam logic [63:0] Q30_HALF_PI = 64'd1686629713;
	localparam logic [63:0] Q30_TWO_PI  = 64'd6746518852;

	localparam int TAYLOR_STEPS = 8;
	localparam int TAYLOR_DIV [TAYLOR_STEPS] = '{6, 20, 42, 72, 110, 156, 210, 272};

	// Unsigned quotient by restoring shift and subtract, for building the tables.
	// Evaluated during elaboration only.
	function automatic logic [63:0] const_quot(input logic [63:0] num, input logic [63:0] den);
		logic [63:0] q;
		logic [64:0] r;
		int i;
		q = '0;
		r = '0;
		for (i = 63; i >= 0; i--) begin
			r = {r[63:0], num[i]};
			if (r >= {1'b0, den}) begin
				r    = r - {1'b0, den};
				q[i] = 1'b1;
			end
		end
		return q;
	endfunction

	// One entry of round(6553.4 * sin(2 * c * 3.14159 * k / L)), in integer steps.
	// Evaluated during elaboration only.
	function automatic logic [SAMPLE_W-1:0] wave_point(input logic fast, input logic two,
		input int k);
		logic [63:0] num;
		logic [63:0] a;
		logic [63:0] x2;
		logic [63:0] term;
		logic [63:0] mag;
		logic [63:0] cyc;
		logic signed [63:0] sum;
		logic neg;
		int n;
		cyc = two ? 64'd2 : 64'd1;
		num = (64'd628318 * cyc * 64'(k)) << 30;
		if (fast) begin
			a = const_quot(num + 64'd50000 * 64'(FAST_LEN), 64'd100000 * 64'(FAST_LEN));
		end else begin
			a = const_quot(num + 64'd50000 * 64'(SLOW_LEN), 64'd100000 * 64'(SLOW_LEN));
		end
		if (a >= Q30_TWO_PI) a = a - Q30_TWO_PI;
		if (a >= Q30_TWO_PI) a = a - Q30_TWO_PI;
		neg = 1'b0;
		if (a > Q30_PI) begin
			a   = a - Q30_PI;
			neg = 1'b1;
		end
		if (a > Q30_HALF_PI) a = Q30_PI - a;
		x2   = (a * a) >> 30;
		term = a;
		sum  = signed'(a);
		for (n = 0; n < TAYLOR_STEPS; n++) begin
			term = const_quot((term * x2) >> 30, 64'(TAYLOR_DIV[n]));
			if (n[0] == 1'b0) begin
				sum = sum - signed'(term);
			end else begin
				sum = sum + signed'(term);
			end
		end
		if (sum < 0) sum = '0;
		mag = const_quot(unsigned'(sum) * 64'd65534 + 64'd5 * Q30_ONE, 64'd10 * Q30_ONE);
		if (mag > 64'd6554) mag = 64'd6554;
		return neg ? SAMPLE_W'(-mag) : SAMPLE_W'(mag);
	endfunction

	function automatic wave_tab_t wave_table(input logic fast, input logic two);
		wave_tab_t t;
		int k;
		for (k = 0; k < SLOW_LEN; k++) begin
			t[k] = (fast && k >= FAST_LEN) ? '0 : wave_point(fast, two, k);
		end
		return t;
	endfunction

	localparam wave_tab_t WAVE_SLOW_ONE = wave_table(1'b0, 1'b0);
	localparam wave_tab_t WAVE_SLOW_TWO = wave_table(1'b0, 1'b1);
	localparam wave_tab_t WAVE_FAST_ONE = wave_table(1'b1, 1'b0);
	localparam wave_tab_t WAVE_FAST_TWO = wave_table(1'b1, 1'b1);

endpackage

@@ hw/rtl/ftrb_if.sv @@
// Handshake channels of the tape tone ring buffer: items in, results out, configuration.
// Depends on ftrb_pkg.

interface ftrb_item_if import ftrb_pkg::*; ();
	logic       valid;
	logic       ready;
	logic [1:0] action;
	logic [1:0] tone;

	modport source (output valid, output action, output tone, input ready);
	modport sink (input valid, input action, input tone, output ready);
endinterface

interface ftrb_result_if import ftrb_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] sample;
	logic                       sample_from_buffer;
	logic [STATUS_W-1:0]        status;
	logic [FILL_W-1:0]          fill_level;
	logic                       fast_mode;

	modport source (output valid, output sample, output sample_from_buffer,
		output status, output fill_level, output fast_mode, input ready);
	modport sink (input valid, input sample, input sample_from_buffer,
		input status, input fill_level, input fast_mode, output ready);
endinterface

interface ftrb_cfg_if import ftrb_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

@@ hw/rtl/ftrb_ring_mem.sv @@
// Single-port sample ring storage with registered read data.
// Depends on ftrb_pkg.

module ftrb_ring_mem import ftrb_pkg::*; (
	input  logic                clk,
	input  ring_req_t           req,
	output logic [SAMPLE_W-1:0] rdata
);

	logic [SAMPLE_W-1:0] mem [RING_DEPTH];
	logic [SAMPLE_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.addr] <= req.wdata;
		end
		rdata_q <= mem[req.addr];
	end

	assign rdata = rdata_q;

endmodule

@@ hw/rtl/ftrb_wave_rom.sv @@
// Constant sine tables for the four tone shapes, plus silence.
// Depends on ftrb_pkg for the tables and the selection type.

module ftrb_wave_rom import ftrb_pkg::*; (
	input  wave_sel_t           sel,
	output logic [SAMPLE_W-1:0] sample
);

	always_comb begin
		if (sel.silent || sel.k > K_LAST_SLOW) begin
			sample = '0;
		end else begin
			case ({sel.fast, sel.two})
				2'b00:   sample = WAVE_SLOW_ONE[sel.k];
				2'b01:   sample = WAVE_SLOW_TWO[sel.k];
				2'b10:   sample = WAVE_FAST_ONE[sel.k];
				2'b11:   sample = WAVE_FAST_TWO[sel.k];
				default: sample = '0;
			endcase
		end
	end

endmodule

@@ hw/rtl/ftrb_seq.sv @@
// Sequencer of the tape tone ring buffer: speed decision, sample write loop,
// zeroing sweep, reads, configuration registers and the result register.
// Depends on ftrb_pkg and the channel interfaces in ftrb_if.

module ftrb_seq import ftrb_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	ftrb_item_if.sink           items,
	ftrb_result_if.source       results,
	ftrb_cfg_if.sink            cfg,
	output ring_req_t           ring_req,
	input  logic [SAMPLE_W-1:0] ring_rdata,
	output wave_sel_t           wave_sel,
	input  logic [SAMPLE_W-1:0] wave_sample
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECIDE,
		ST_WRITE,
		ST_CLEAR,
		ST_RDWAIT,
		ST_EMIT
	} state_t;

	state_t              state_q;
	tone_t               tone_q;
	logic                sound_q;
	logic                hyst_q;
	logic                speed_q;
	logic [ADDR_W-1:0]   fill_q;
	logic [ADDR_W-1:0]   rp_q;
	logic [ADDR_W-1:0]   wp_q;
	logic [ADDR_W-1:0]   cnt_q;
	logic [SAMPLE_W-1:0] sample_q;
	logic                from_buf_q;
	status_t             status_q;

	logic                out_valid_q;
	logic [SAMPLE_W-1:0] out_sample_q;
	logic                out_from_buf_q;
	status_t             out_status_q;
	logic [ADDR_W-1:0]   out_fill_q;
	logic                out_fast_q;

	logic                fast_n;
	logic [CNT_W-1:0]    len_sum;
	logic [CNT_W-1:0]    start_sum;
	logic [ADDR_W-1:0]   start_wrap;
	logic [ADDR_W-1:0]   wp_inc;
	logic [ADDR_W-1:0]   rp_inc;
	logic [K_W-1:0]      k_last;
	logic                item_acc;

	assign item_acc = items.valid && items.ready;

	// Speed mode as it stands once this tone item has looked at the fill.
	always_comb begin
		if (hyst_q) begin
			if (!speed_q && fill_q >= FILL_3Q) begin
				fast_n = 1'b1;
			end else if (speed_q && fill_q <= FILL_1Q) begin
				fast_n = 1'b0;
			end else begin
				fast_n = speed_q;
			end
		end else begin
			fast_n = (fill_q >= FILL_HALF);
		end
	end

	assign len_sum    = {1'b0, fill_q} + (fast_n ? LEN_FAST : LEN_SLOW);
	assign start_sum  = {1'b0, rp_q} + {1'b0, fill_q};
	assign start_wrap = (start_sum >= DEPTH_C) ? ADDR_W'(start_sum - DEPTH_C)
		: start_sum[ADDR_W-1:0];
	assign wp_inc     = (wp_q == PTR_LAST) ? '0 : wp_q + 1'b1;
	assign rp_inc     = (rp_q == PTR_LAST) ? '0 : rp_q + 1'b1;
	assign k_last     = speed_q ? K_LAST_FAST : K_LAST_SLOW;

	assign wave_sel.fast   = speed_q;
	assign wave_sel.two    = (tone_q != TONE_SPACE);
	assign wave_sel.silent = (tone_q == TONE_SILENCE);
	assign wave_sel.k      = cnt_q[K_W-1:0];

	assign ring_req.we    = (state_q == ST_WRITE) || (state_q == ST_CLEAR);
	assign ring_req.addr  = ring_req.we ? wp_q : rp_q;
	assign ring_req.wdata = (state_q == ST_WRITE) ? wave_sample : '0;

	assign items.ready = (state_q == ST_IDLE);
	assign cfg.ready   = 1'b1;

	assign results.valid              = out_valid_q;
	assign results.sample             = out_sample_q;
	assign results.sample_from_buffer = out_from_buf_q;
	assign results.status             = out_status_q;
	assign results.fill_level         = FILL_W'(out_fill_q);
	assign results.fast_mode          = out_fast_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			tone_q         <= TONE_SPACE;
			sound_q        <= 1'b0;
			hyst_q         <= 1'b0;
			speed_q        <= 1'b0;
			fill_q         <= '0;
			rp_q           <= '0;
			wp_q           <= '0;
			cnt_q          <= '0;
			sample_q       <= '0;
			from_buf_q     <= 1'b0;
			status_q       <= STAT_NOT_TONE;
			out_valid_q    <= 1'b0;
			out_sample_q   <= '0;
			out_from_buf_q <= 1'b0;
			out_status_q   <= STAT_NOT_TONE;
			out_fill_q     <= '0;
			out_fast_q     <= 1'b0;
		end else begin
			if (cfg.valid) begin
				if (cfg.index == CFG_SOUND_ENABLE) begin
					sound_q <= cfg.data[0];
				end else if (cfg.index == CFG_HYSTERESIS) begin
					hyst_q <= cfg.data[0];
				end
			end

			// The emit step reloads the result register itself.
			if (out_valid_q && results.ready && state_q != ST_EMIT) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (item_acc) begin
						sample_q   <= '0;
						from_buf_q <= 1'b0;
						status_q   <= STAT_NOT_TONE;
						case (action_t'(items.action))
							ACT_TONE: begin
								tone_q  <= tone_t'(items.tone);
								wp_q    <= start_wrap;
								state_q <= ST_DECIDE;
							end
							ACT_READ: begin
								state_q <= (fill_q == '0) ? ST_EMIT : ST_RDWAIT;
							end
							ACT_FLUSH: begin
								fill_q  <= '0;
								state_q <= ST_EMIT;
							end
							ACT_ACTIVATE: begin
								wp_q    <= rp_q;
								cnt_q   <= '0;
								state_q <= ST_CLEAR;
							end
							default: state_q <= ST_EMIT;
						endcase
					end
				end
				ST_DECIDE: begin
					speed_q <= fast_n;
					cnt_q   <= '0;
					if (tone_q == TONE_LEADER && fast_n) begin
						status_q <= STAT_SKIPPED;
						state_q  <= ST_EMIT;
					end else if (!sound_q) begin
						fill_q   <= '0;
						status_q <= STAT_SOUND_OFF;
						state_q  <= ST_EMIT;
					end else if (len_sum >= DEPTH_C) begin
						status_q <= STAT_FULL;
						state_q  <= ST_EMIT;
					end else begin
						state_q <= ST_WRITE;
					end
				end
				ST_WRITE: begin
					wp_q   <= wp_inc;
					cnt_q  <= cnt_q + 1'b1;
					fill_q <= fill_q + 1'b1;
					if (cnt_q[K_W-1:0] == k_last) begin
						status_q <= STAT_WRITTEN;
						state_q  <= ST_EMIT;
					end
				end
				ST_CLEAR: begin
					wp_q  <= wp_inc;
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CLEAR_LAST) begin
						fill_q  <= FILL_HALF;
						state_q <= ST_EMIT;
					end
				end
				ST_RDWAIT: begin
					sample_q   <= ring_rdata;
					from_buf_q <= 1'b1;
					rp_q       <= rp_inc;
					fill_q     <= fill_q - 1'b1;
					state_q    <= ST_EMIT;
				end
				ST_EMIT: begin
					if (!out_valid_q || results.ready) begin
						out_valid_q    <= 1'b1;
						out_sample_q   <= sample_q;
						out_from_buf_q <= from_buf_q;
						out_status_q   <= status_q;
						out_fill_q     <= fill_q;
						out_fast_q     <= speed_q;
						state_q        <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// An accepted item always keeps the sequencer busy for the next cycle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		item_acc |=> !items.ready)
		else $error("ftrb_seq: ready after an accepted transaction");

	// The speed mode only moves on the decision step of a tone item.
	a_speed_only_in_decide: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(speed_q) |-> $past(state_q == ST_DECIDE))
		else $error("ftrb_seq: speed mode changed outside a tone decision");

	// The read pointer only advances when a stored sample is popped.
	a_rp_only_on_pop: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(rp_q) |-> $past(state_q == ST_RDWAIT))
		else $error("ftrb_seq: read pointer moved without a pop");

	// A popped sample is never reported together with a tone status.
	a_pop_not_tone: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_from_buf_q) |-> (out_status_q == STAT_NOT_TONE))
		else $error("ftrb_seq: buffered sample carries a tone status");

endmodule

@@ hw/rtl/fsk_tape_tone_ring_buffer.sv @@
// Top level of the FSK tape tone ring buffer.
// Depends on ftrb_pkg, the interfaces in ftrb_if, ftrb_seq, ftrb_ring_mem and ftrb_wave_rom.

// This block turns tape symbols into FSK audio samples held in a ring buffer and hands the
// samples back one at a time. Each item is one transaction on the item channel and always
// produces exactly one transaction on the result channel, which carries the popped sample
// (zero unless a read found data), the status, the fill level and the speed mode after the
// item. The block works on one item at a time and drops ready while it is busy; a result
// sits in an output register, so the next item is taken while that result still waits.
// Timing is set by the single-port sample memory, which takes one access per cycle, and by
// the sequencer walking one sample per cycle: a tone item that is written walks its whole
// period, a tone item that is skipped, dropped or silenced writes nothing, and an activate
// item zeroes the half of the ring that becomes readable, one entry per cycle. Configuration
// writes are always accepted at once and must only be made while the block is idle. After
// reset the sample memory content is undefined; it is only ever read where it has been
// written or zeroed.

module fsk_tape_tone_ring_buffer import ftrb_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	ftrb_item_if.sink     items,
	ftrb_result_if.source results,
	ftrb_cfg_if.sink      cfg
);

	ring_req_t           ring_req;
	logic [SAMPLE_W-1:0] ring_rdata;
	wave_sel_t           wave_sel;
	logic [SAMPLE_W-1:0] wave_sample;

	// The sequencer owns all control state and the result register.
	ftrb_seq u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.items       (items),
		.results     (results),
		.cfg         (cfg),
		.ring_req    (ring_req),
		.ring_rdata  (ring_rdata),
		.wave_sel    (wave_sel),
		.wave_sample (wave_sample)
	);

	// Sample storage: one write or one read each cycle, read data registered.
	ftrb_ring_mem u_ring_mem (
		.clk   (clk),
		.req   (ring_req),
		.rdata (ring_rdata)
	);

	// Sine tables for space and mark periods in both speed modes.
	ftrb_wave_rom u_wave_rom (
		.sel    (wave_sel),
		.sample (wave_sample)
	);

endmodule

@@ verif/fsk_tape_tone_ring_buffer_tb.sv @@
// Self-checking testbench of the FSK tape tone ring buffer.
// Depends on ftrb_pkg, the channel interfaces in ftrb_if and the top level fsk_tape_tone_ring_buffer.

module fsk_tape_tone_ring_buffer_tb;
	import ftrb_pkg::*;

	// The run stops feeding items once this many have been accepted.
	localparam int ITEM_TARGET = 1250;
	// The slowest single transaction is an activate item, which zeroes RING_DEPTH/2 entries, with
	// the result then held up by random receiver stalls. The watchdog allows several times that
	// with no transaction on any channel before it gives up.
	localparam int WATCHDOG_LIMIT = 40000;
	// Cycles left to run once every result has arrived, to catch a stray late transaction.
	localparam int TAIL_CYCLES = 60;

	// Register indexes with no register behind them; writes there must change nothing.
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = CFG_IDX_W'(3);

	// One result transaction as the block should deliver it.
	typedef struct {
		logic signed [SAMPLE_W-1:0] sample;
		logic                       from_buf;
		status_t                    status;
		logic [FILL_W-1:0]          fill;
		logic                       fast;
	} tape_outcome_t;

	// One row of the directed table: either a register write or an item. Items whose result
	// is obvious carry it in the row; the rest are left to the model of the buffer.
	typedef struct {
		logic                  is_cfg;
		logic [CFG_IDX_W-1:0]  idx;
		logic [CFG_DATA_W-1:0] data;
		action_t               act;
		tone_t                 tn;
		logic                  typed;
		tape_outcome_t         want;
	} plan_row_t;

	// Shapes of the random bursts: filling the ring towards full, draining it, and a mixture.
	typedef enum int {
		BURST_FILL,
		BURST_DRAIN,
		BURST_MIXED
	} burst_t;

	logic clk;
	logic arst_n;

	ftrb_item_if   items ();
	ftrb_result_if results ();
	ftrb_cfg_if    cfg ();

	fsk_tape_tone_ring_buffer uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.items   (items),
		.results (results),
		.cfg     (cfg)
	);

	// Model of the buffer: its own copy of the wave tables, the ring, the pointers, the speed
	// mode and both registers.
	logic signed [SAMPLE_W-1:0] tone_tab [2][2][SLOW_LEN];   // [fast][double frequency][k]
	logic signed [SAMPLE_W-1:0] tape_ring [RING_DEPTH];
	int unsigned                ring_rd;
	int unsigned                ring_fill;
	logic                       speed_fast_q;
	logic                       sound_on;
	logic                       hyst_on;

	// Results still owed by the block, oldest first.
	tape_outcome_t tape_outcomes [$];

	int error_count;
	int items_sent;
	int reg_writes;
	int activates_sent;
	int status_tally [5];
	int buffered_reads;
	int send_idle_pct;
	int recv_idle_pct;
	int idle_cycles;

	// One wave table entry, round(6553.4 * sin(2 * c * 3.14159 * k / L)), worked out in Q30
	// integer steps so that it matches the tables of the block bit for bit.
	function automatic logic signed [SAMPLE_W-1:0] sine_entry(input int cycles, input int k,
		input int len);
		logic [63:0]        ang;
		logic [63:0]        sq;
		logic [63:0]        term;
		logic [63:0]        mag;
		logic signed [63:0] acc;
		logic [SAMPLE_W-1:0] m16;
		logic               neg;
		int                 n;
		ang = (64'd314159 * 64'd2 * 64'(cycles) * 64'(k)) << 30;
		ang = (ang + 64'd50000 * 64'(len)) / (64'd100000 * 64'(len));
		while (ang >= Q30_TWO_PI)
			ang = ang - Q30_TWO_PI;
		neg = 1'b0;
		if (ang > Q30_PI) begin
			ang = ang - Q30_PI;
			neg = 1'b1;
		end
		if (ang > Q30_HALF_PI)
			ang = Q30_PI - ang;
		sq   = (ang * ang) >> 30;
		term = ang;
		acc  = $signed(ang);
		for (n = 1; n <= 8; n++) begin
			term = ((term * sq) >> 30) / 64'((2 * n) * (2 * n + 1));
			if (n % 2 == 1)
				acc = acc - $signed(term);
			else
				acc = acc + $signed(term);
		end
		if (acc < 0)
			acc = 0;
		mag = ($unsigned(acc) * 64'd65534 + 64'd5 * Q30_ONE) / (64'd10 * Q30_ONE);
		if (mag > 64'd6554)
			mag = 64'd6554;
		m16 = mag[SAMPLE_W-1:0];
		return neg ? $signed(-m16) : $signed(m16);
	endfunction

	// Applies one item to the model and returns the result it should give.
	function automatic tape_outcome_t advance_tape(input action_t act, input tone_t tn);
		tape_outcome_t o;
		int unsigned   len;
		int unsigned   pos;
		int            n;
		o.sample   = '0;
		o.from_buf = 1'b0;
		o.status   = STAT_NOT_TONE;
		case (act)
			ACT_TONE: begin
				// The speed mode is settled first, from the fill before this symbol.
				if (hyst_on) begin
					if (!speed_fast_q && ring_fill >= (3 * RING_DEPTH) / 4)
						speed_fast_q = 1'b1;
					else if (speed_fast_q && ring_fill <= RING_DEPTH / 4)
						speed_fast_q = 1'b0;
				end else begin
					speed_fast_q = (ring_fill >= RING_DEPTH / 2);
				end
				len = speed_fast_q ? FAST_LEN : SLOW_LEN;
				if (tn == TONE_LEADER && speed_fast_q) begin
					o.status = STAT_SKIPPED;
				end else if (!sound_on) begin
					ring_fill = 0;
					o.status  = STAT_SOUND_OFF;
				end else if (ring_fill + len >= RING_DEPTH) begin
					o.status = STAT_FULL;
				end else begin
					pos = (ring_rd + ring_fill) % RING_DEPTH;
					for (n = 0; n < len; n++) begin
						tape_ring[pos] = (tn == TONE_SILENCE) ? '0 :
							tone_tab[speed_fast_q][tn != TONE_SPACE][n];
						pos = (pos + 1) % RING_DEPTH;
					end
					ring_fill = ring_fill + len;
					o.status  = STAT_WRITTEN;
				end
			end
			ACT_READ: begin
				if (ring_fill > 0) begin
					o.sample   = tape_ring[ring_rd];
					o.from_buf = 1'b1;
					ring_rd    = (ring_rd + 1) % RING_DEPTH;
					ring_fill  = ring_fill - 1;
				end
			end
			ACT_FLUSH: begin
				ring_fill = 0;
			end
			default: begin
				foreach (tape_ring[i])
					tape_ring[i] = '0;
				ring_fill = RING_DEPTH / 2;
			end
		endcase
		o.fill = ring_fill[FILL_W-1:0];
		o.fast = speed_fast_q;
		return o;
	endfunction

	function automatic plan_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] data);
		plan_row_t r;
		r        = '{default: '0, act: ACT_TONE, tn: TONE_SPACE, want: '{default: '0,
			status: STAT_WRITTEN}};
		r.is_cfg = 1'b1;
		r.idx    = idx;
		r.data   = data;
		return r;
	endfunction

	function automatic plan_row_t item_row(input action_t act, input tone_t tn);
		plan_row_t r;
		r     = cfg_row(CFG_SOUND_ENABLE, 1'b0);
		r.is_cfg = 1'b0;
		r.act = act;
		r.tn  = tn;
		return r;
	endfunction

	function automatic plan_row_t known_row(input action_t act, input tone_t tn,
		input int smp, input logic fb, input status_t st, input int fill, input logic fast);
		plan_row_t r;
		r                = item_row(act, tn);
		r.typed          = 1'b1;
		r.want.sample    = SAMPLE_W'(smp);
		r.want.from_buf  = fb;
		r.want.status    = st;
		r.want.fill      = FILL_W'(fill);
		r.want.fast      = fast;
		return r;
	endfunction

	// Tone mix for the filling bursts: leader is kept rare, since in fast mode it is skipped
	// and would stop the ring from ever getting full.
	function automatic tone_t fill_tone();
		if ($urandom_range(0, 9) == 0)
			return TONE_LEADER;
		case ($urandom_range(0, 2))
			0:       return TONE_SPACE;
			1:       return TONE_MARK;
			default: return TONE_SILENCE;
		endcase
	endfunction

	function automatic action_t burst_action(input burst_t b);
		int r;
		r = $urandom_range(0, 99);
		case (b)
			BURST_FILL:  return (r < 96) ? ACT_TONE : (r < 99) ? ACT_READ : ACT_FLUSH;
			BURST_DRAIN: return (r < 80) ? ACT_READ : (r < 96) ? ACT_TONE : ACT_FLUSH;
			default: begin
				if (r < 40) return ACT_TONE;
				if (r < 85) return ACT_READ;
				if (r < 97) return ACT_FLUSH;
				return ACT_ACTIVATE;
			end
		endcase
	endfunction

	// Idling follows the number of items so far: the receiver idles most in the first third, the
	// sender in the second, and in the last third both run flat out.
	function automatic void set_idling();
		if (items_sent < ITEM_TARGET / 3) begin
			send_idle_pct = 35;
			recv_idle_pct = 62;
		end else if (items_sent < (2 * ITEM_TARGET) / 3) begin
			send_idle_pct = 62;
			recv_idle_pct = 35;
		end else begin
			send_idle_pct = 0;
			recv_idle_pct = 0;
		end
	endfunction

	// Offers one item, after a random number of idle cycles, and waits for its transaction.
	// Valid is left high on return so that back-to-back items never drop it within a step.
	// Once accepted the item is run through the model and its result is queued; a directed
	// row with a typed result queues that instead.
	task automatic issue_item(input action_t act, input tone_t tn, input logic typed,
		input tape_outcome_t given);
		tape_outcome_t o;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			items.valid <= 1'b0;
			@(posedge clk);
		end
		items.valid  <= 1'b1;
		items.action <= act;
		items.tone   <= tn;
		@(posedge clk);
		while (!items.ready)
			@(posedge clk);
		o = advance_tape(act, tn);
		status_tally[o.status]++;
		if (o.from_buf)
			buffered_reads++;
		if (act == ACT_ACTIVATE)
			activates_sent++;
		tape_outcomes.push_back(typed ? given : o);
		items_sent++;
		set_idling();
	endtask

	// Holds the sender back until the block has handed over every result it owes, so that
	// the block is idle.
	task automatic settle();
		items.valid <= 1'b0;
		@(posedge clk);
		while (tape_outcomes.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data  <= val;
		@(posedge clk);
		while (!cfg.ready)
			@(posedge clk);
		if (idx == CFG_SOUND_ENABLE)
			sound_on = val[0];
		else if (idx == CFG_HYSTERESIS)
			hyst_on = val[0];
		reg_writes++;
		// Valid is lowered before returning, so that a following write does not lower and raise valid at once.
		cfg.valid <= 1'b0;
		@(posedge clk);
	endtask

	initial begin
		clk = 1'b0;
	end

	always #5 clk = ~clk;

	// Receiver: stalls at random and checks every result transaction against the oldest
	// outstanding expectation, field by field.
	always @(posedge clk) begin : result_check
		tape_outcome_t w;
		results.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
		if (arst_n && results.valid && results.ready) begin
			if (tape_outcomes.size() == 0) begin
				$error("result transaction with no result outstanding");
				error_count++;
			end else begin
				w = tape_outcomes.pop_front();
				if (results.sample !== w.sample) begin
					$error("sample: expected %0d, got %0d", w.sample, results.sample);
					error_count++;
				end
				if (results.sample_from_buffer !== w.from_buf) begin
					$error("sample_from_buffer: expected %0d, got %0d", w.from_buf,
						results.sample_from_buffer);
					error_count++;
				end
				if (results.status !== w.status) begin
					$error("status: expected %0d, got %0d", w.status, results.status);
					error_count++;
				end
				if (results.fill_level !== w.fill) begin
					$error("fill_level: expected %0d, got %0d", w.fill, results.fill_level);
					error_count++;
				end
				if (results.fast_mode !== w.fast) begin
					$error("fast_mode: expected %0d, got %0d", w.fast, results.fast_mode);
					error_count++;
				end
			end
		end
	end

	// Watchdog: counts cycles in which no channel completes a transaction.
	always @(posedge clk) begin
		if ((items.valid && items.ready) || (results.valid && results.ready) ||
			(cfg.valid && cfg.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
			$display("no transaction for %0d cycles", WATCHDOG_LIMIT);
			$display("fsk_tape_tone_ring_buffer_tb failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin : stimulus
		plan_row_t directed_plan [$];
		burst_t    burst;
		int        phase;
		int        burst_len;
		int        i;
		logic      snd;
		logic      hys;
		action_t   a;
		tone_t     t;

		// Every input driven from here is at a known value from time zero; the receiver's
		// ready follows from the first clock edge, well inside reset.
		arst_n        = 1'b0;
		items.valid   <= 1'b0;
		items.action  <= ACT_TONE;
		items.tone    <= TONE_SPACE;
		cfg.valid     <= 1'b0;
		cfg.index     <= CFG_SOUND_ENABLE;
		cfg.data      <= '0;
		items_sent     = 0;
		reg_writes     = 0;
		activates_sent = 0;
		buffered_reads = 0;
		foreach (status_tally[s])
			status_tally[s] = 0;
		set_idling();

		// The model's own wave tables and its reset state.
		for (int f = 0; f < 2; f++)
			for (int c = 0; c < 2; c++)
				for (int k = 0; k < SLOW_LEN; k++)
					tone_tab[f][c][k] = (k < (f ? FAST_LEN : SLOW_LEN)) ?
						sine_entry(c + 1, k, f ? FAST_LEN : SLOW_LEN) : '0;
		foreach (tape_ring[j])
			tape_ring[j] = '0;
		ring_rd      = 0;
		ring_fill    = 0;
		speed_fast_q = 1'b0;
		sound_on     = 1'b0;
		hyst_on      = 1'b0;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. Straight after reset sound is off and the threshold is at half.
		// An empty read pads with zero, a tone with sound off clears the ring, a flush of an
		// empty ring changes nothing.
		directed_plan.push_back(known_row(ACT_READ, TONE_SPACE, 0, 1'b0, STAT_NOT_TONE, 0, 1'b0));
		directed_plan.push_back(known_row(ACT_TONE, TONE_SPACE, 0, 1'b0, STAT_SOUND_OFF, 0, 1'b0));
		directed_plan.push_back(known_row(ACT_FLUSH, TONE_MARK, 0, 1'b0, STAT_NOT_TONE, 0, 1'b0));
		directed_plan.push_back(cfg_row(CFG_SOUND_ENABLE, 1'b1));
		// Every tone in slow mode appends SLOW_LEN samples, leader included.
		directed_plan.push_back(known_row(ACT_TONE, TONE_SPACE, 0, 1'b0, STAT_WRITTEN, 37, 1'b0));
		directed_plan.push_back(known_row(ACT_TONE, TONE_MARK, 0, 1'b0, STAT_WRITTEN, 74, 1'b0));
		directed_plan.push_back(known_row(ACT_TONE, TONE_LEADER, 0, 1'b0, STAT_WRITTEN, 111, 1'b0));
		directed_plan.push_back(known_row(ACT_TONE, TONE_SILENCE, 0, 1'b0, STAT_WRITTEN, 148, 1'b0));
		// The first sample of any sine table is zero, but it still comes from the buffer.
		directed_plan.push_back(known_row(ACT_READ, TONE_SPACE, 0, 1'b1, STAT_NOT_TONE, 147, 1'b0));
		directed_plan.push_back(item_row(ACT_READ, TONE_MARK));
		directed_plan.push_back(item_row(ACT_READ, TONE_LEADER));
		directed_plan.push_back(item_row(ACT_READ, TONE_SILENCE));
		// Activate makes half the ring readable silence and leaves the speed mode alone.
		directed_plan.push_back(known_row(ACT_ACTIVATE, TONE_SILENCE, 0, 1'b0, STAT_NOT_TONE,
			RING_DEPTH / 2, 1'b0));
		directed_plan.push_back(known_row(ACT_READ, TONE_SPACE, 0, 1'b1, STAT_NOT_TONE,
			RING_DEPTH / 2 - 1, 1'b0));
		// Just under half is still slow; the next tone sees half and goes fast, so its leader
		// is skipped; a fast period is FAST_LEN samples.
		directed_plan.push_back(known_row(ACT_TONE, TONE_LEADER, 0, 1'b0, STAT_WRITTEN, 8228, 1'b0));
		directed_plan.push_back(known_row(ACT_TONE, TONE_LEADER, 0, 1'b0, STAT_SKIPPED, 8228, 1'b1));
		directed_plan.push_back(known_row(ACT_TONE, TONE_SILENCE, 0, 1'b0, STAT_WRITTEN, 8264, 1'b1));
		directed_plan.push_back(item_row(ACT_TONE, TONE_SPACE));
		directed_plan.push_back(item_row(ACT_READ, TONE_SPACE));
		directed_plan.push_back(cfg_row(CFG_HYSTERESIS, 1'b1));
		directed_plan.push_back(item_row(ACT_TONE, TONE_MARK));
		// A flush does not touch the speed mode; the next tone finds the ring at or below a
		// quarter and drops back to slow, so its leader is written.
		directed_plan.push_back(known_row(ACT_FLUSH, TONE_SPACE, 0, 1'b0, STAT_NOT_TONE, 0, 1'b1));
		directed_plan.push_back(known_row(ACT_TONE, TONE_LEADER, 0, 1'b0, STAT_WRITTEN, 37, 1'b0));
		// Writes to indexes with no register must be accepted and ignored.
		directed_plan.push_back(cfg_row(CFG_SPARE_A, 1'b1));
		directed_plan.push_back(cfg_row(CFG_SPARE_B, 1'b0));
		directed_plan.push_back(cfg_row(CFG_SOUND_ENABLE, 1'b0));
		directed_plan.push_back(known_row(ACT_TONE, TONE_LEADER, 0, 1'b0, STAT_SOUND_OFF, 0, 1'b0));
		directed_plan.push_back(known_row(ACT_READ, TONE_MARK, 0, 1'b0, STAT_NOT_TONE, 0, 1'b0));

		foreach (directed_plan[r]) begin
			if (directed_plan[r].is_cfg) begin
				settle();
				write_reg(directed_plan[r].idx, directed_plan[r].data);
			end else begin
				issue_item(directed_plan[r].act, directed_plan[r].tn, directed_plan[r].typed,
					directed_plan[r].want);
			end
		end

		// Random part, in bursts. Before each burst the sender waits until the block has
		// returned every result, and only then are the registers rewritten. The first burst
		// fills the ring under hysteresis, the second drains it, the third is a mixture under the
		// single threshold; every filling burst starts from an activate so that the three-quarter
		// point and a full ring are within reach. Sound stays on while filling.
		phase = 0;
		while (items_sent < ITEM_TARGET) begin
			settle();
			burst = (phase < 3) ? burst_t'(phase) : burst_t'($urandom_range(0, 2));
			snd   = (burst == BURST_FILL) ? 1'b1 : ($urandom_range(0, 4) != 0);
			hys   = (phase == 0) ? 1'b1 : (phase == 2) ? 1'b0 : 1'($urandom_range(0, 1));
			write_reg(CFG_SOUND_ENABLE, snd);
			write_reg(CFG_HYSTERESIS, hys);
			if ($urandom_range(0, 5) == 0)
				write_reg($urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B,
					1'($urandom_range(0, 1)));
			case (burst)
				BURST_FILL: begin
					issue_item(ACT_ACTIVATE, tone_t'($urandom_range(0, 3)), 1'b0,
						'{default: '0, status: STAT_WRITTEN});
					burst_len = $urandom_range(300, 360);
				end
				BURST_DRAIN: burst_len = $urandom_range(40, 120);
				default:     burst_len = $urandom_range(30, 80);
			endcase
			for (i = 0; i < burst_len && items_sent < ITEM_TARGET; i++) begin
				a = burst_action(burst);
				t = (burst == BURST_FILL) ? fill_tone() : tone_t'($urandom_range(0, 3));
				issue_item(a, t, 1'b0, '{default: '0, status: STAT_WRITTEN});
			end
			phase++;
		end

		// Wind down: all results in, then a short tail in which nothing more may arrive.
		settle();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("%0d items in %0d bursts, %0d register writes, %0d activates, %0d buffered reads",
			items_sent, phase, reg_writes, activates_sent, buffered_reads);
		$display("tones written %0d, leaders skipped %0d, dropped on full %0d, cleared %0d",
			status_tally[STAT_WRITTEN], status_tally[STAT_SKIPPED], status_tally[STAT_FULL],
			status_tally[STAT_SOUND_OFF]);
		if (error_count == 0 && tape_outcomes.size() == 0) begin
			$display("fsk_tape_tone_ring_buffer_tb passed");
		end else begin
			$display("%0d mismatches, %0d results outstanding", error_count,
				tape_outcomes.size());
			$display("fsk_tape_tone_ring_buffer_tb failed");
		end
		$finish;
	end

endmodule

@@ sim.f @@
hw/rtl/ftrb_pkg.sv
hw/rtl/ftrb_if.sv
hw/rtl/ftrb_ring_mem.sv
hw/rtl/ftrb_wave_rom.sv
hw/rtl/ftrb_seq.sv
hw/rtl/fsk_tape_tone_ring_buffer.sv
verif/fsk_tape_tone_ring_buffer_tb.sv
